/* src/cgsb_pkg.sv */
package cgsb_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int UNIT_LAT  = WORD_W + 2;
  localparam int CFG_IDX_W = 4;
  localparam int GAMMA_W   = 19;
  localparam int DIM_W     = 2;
  localparam int NUM_BC    = 5;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [WORD_W-1:0]        uword_t;
  typedef logic [2*WORD_W-1:0]      dword_t;

  localparam word_t MAXW   = word_t'({1'b0, {(WORD_W-1){1'b1}}});
  localparam word_t MINW   = word_t'({1'b1, {(WORD_W-1){1'b0}}});
  localparam word_t ONE_FX = word_t'(1 << FRAC_BITS);

  localparam dword_t LIM_POS = dword_t'(MAXW);
  localparam dword_t LIM_NEG = dword_t'(MAXW) + dword_t'(1);

  localparam logic [CFG_IDX_W-1:0] REG_DIMENSION   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VISCOUS     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BC_DENSITY  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BC_VEL_X    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BC_VEL_Y    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BC_VEL_Z    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BC_PRESSURE = 4'd7;

  localparam logic [DIM_W-1:0]   DIM_RST   = 2'd3;
  localparam logic [GAMMA_W-1:0] GAMMA_RST = 19'd91750;

  typedef enum logic [1:0] {
    OP_DIRICHLET = 2'd0,
    OP_OUTFLOW   = 2'd1,
    OP_WALL      = 2'd2,
    OP_COPY      = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] opcode;
    word_t      density_in;
    word_t      vel_x_in;
    word_t      vel_y_in;
    word_t      vel_z_in;
    word_t      pressure_in;
    word_t      normal_x;
    word_t      normal_y;
    word_t      normal_z;
  } in_word_t;

  typedef struct packed {
    word_t density_out;
    word_t vel_x_out;
    word_t vel_y_out;
    word_t vel_z_out;
    word_t pressure_out;
    logic  status;
  } out_word_t;

  typedef struct packed {
    op_t         op;
    word_t       rho;
    word_t       p;
    word_t [2:0] u;
    word_t [2:0] n;
    word_t [2:0] nsq;
    word_t [2:0] un;
    word_t       gp;
    word_t       nn;
    word_t       dot;
    word_t       area;
    word_t       q;
    word_t       d;
    word_t       alpha;
    word_t [2:0] wall;
    word_t       c;
    word_t       a;
    word_t       ac;
    word_t       rho_g;
    word_t [2:0] acn;
    logic        fault_out;
    logic        fault_wall;
  } ctx_t;

  function automatic uword_t mag(input word_t a);
    return a[WORD_W-1] ? uword_t'(~a + 1'b1) : uword_t'(a);
  endfunction

  function automatic word_t sat_mag(input dword_t m, input logic neg);
    uword_t t;
    t = ~m[WORD_W-1:0] + 1'b1;
    if (neg) begin
      if (m > LIM_NEG) return MINW;
      return word_t'(t);
    end
    if (m > LIM_POS) return MAXW;
    return word_t'(m[WORD_W-1:0]);
  endfunction

  function automatic word_t fmul(input word_t a, input word_t b);
    dword_t pr;
    pr = dword_t'(mag(a)) * dword_t'(mag(b));
    return sat_mag(pr >> FRAC_BITS, a[WORD_W-1] ^ b[WORD_W-1]);
  endfunction

  function automatic word_t sadd(input word_t a, input word_t b);
    logic signed [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? MINW : MAXW;
    return word_t'(s[WORD_W-1:0]);
  endfunction

  function automatic word_t ssub(input word_t a, input word_t b);
    logic signed [WORD_W:0] s;
    s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? MINW : MAXW;
    return word_t'(s[WORD_W-1:0]);
  endfunction

endpackage

/* src/cgsb_if.sv */
interface cgsb_face_if;
  logic               valid;
  logic               ready;
  cgsb_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cgsb_ghost_if;
  logic                valid;
  logic                ready;
  cgsb_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cgsb_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cgsb_pkg::CFG_IDX_W-1:0]    index;
  logic [cgsb_pkg::WORD_W-1:0]       data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/cgsb_div.sv */
module cgsb_div (
  input  logic            clk,
  input  logic            en,
  input  cgsb_pkg::word_t num,
  input  cgsb_pkg::word_t den,
  output cgsb_pkg::word_t quo,
  output logic            dz
);

  localparam int W = cgsb_pkg::WORD_W;
  localparam int F = cgsb_pkg::FRAC_BITS;

  typedef struct packed {
    logic [W-1:0] rem;
    logic [W-1:0] low;
    logic [W-1:0] qt;
    logic [W-1:0] dv;
    logic         neg;
    logic         over;
    logic         zero;
  } dst_t;

  dst_t st      [0:W];
  dst_t st_next [0:W];

  always_comb begin
    logic [W-1:0] ma;
    logic [W-1:0] md;
    logic [W:0]   t;
    logic         ge;
    ma = cgsb_pkg::mag(num);
    md = cgsb_pkg::mag(den);
    st_next[0].rem  = ma >> (W - F);
    st_next[0].low  = ma << F;
    st_next[0].qt   = '0;
    st_next[0].dv   = md;
    st_next[0].neg  = num[W-1] ^ den[W-1];
    st_next[0].over = (ma >> (W - F)) >= md;
    st_next[0].zero = (md == '0);
    for (int k = 0; k < W; k++) begin
      t  = {st[k].rem, st[k].low[W-1]};
      ge = t >= {1'b0, st[k].dv};
      st_next[k+1]     = st[k];
      st_next[k+1].rem = ge ? W'(t - {1'b0, st[k].dv}) : t[W-1:0];
      st_next[k+1].low = st[k].low << 1;
      st_next[k+1].qt  = {st[k].qt[W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st <= st_next;
      if (st[W].zero) begin
        quo <= cgsb_pkg::MAXW;
        dz  <= 1'b1;
      end else if (st[W].over) begin
        quo <= st[W].neg ? cgsb_pkg::MINW : cgsb_pkg::MAXW;
        dz  <= 1'b0;
      end else begin
        quo <= cgsb_pkg::sat_mag(cgsb_pkg::dword_t'(st[W].qt), st[W].neg);
        dz  <= 1'b0;
      end
    end
  end

endmodule

/* src/cgsb_sqrt.sv */
module cgsb_sqrt (
  input  logic            clk,
  input  logic            en,
  input  cgsb_pkg::word_t a,
  output cgsb_pkg::word_t root,
  output logic            neg
);

  localparam int W = cgsb_pkg::WORD_W;
  localparam int F = cgsb_pkg::FRAC_BITS;

  typedef struct packed {
    logic [W+1:0]   rem;
    logic [2*W-1:0] x;
    logic [W-1:0]   rt;
    logic           neg;
  } sst_t;

  sst_t st      [0:W];
  sst_t st_next [0:W];

  always_comb begin
    logic [W+3:0] tmp;
    logic [W+3:0] tr;
    logic         ge;
    st_next[0].rem = '0;
    st_next[0].x   = (2*W)'(a[W-1:0]) << F;
    st_next[0].rt  = '0;
    st_next[0].neg = a[W-1];
    for (int k = 0; k < W; k++) begin
      tmp = {st[k].rem, st[k].x[2*W-1 -: 2]};
      tr  = {2'b00, st[k].rt, 2'b01};
      ge  = tmp >= tr;
      st_next[k+1]     = st[k];
      st_next[k+1].rem = ge ? (W+2)'(tmp - tr) : tmp[W+1:0];
      st_next[k+1].x   = st[k].x << 2;
      st_next[k+1].rt  = {st[k].rt[W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st   <= st_next;
      root <= st[W].neg ? cgsb_pkg::MAXW : cgsb_pkg::word_t'(st[W].rt);
      neg  <= st[W].neg;
    end
  end

endmodule

/* src/cgsb_delay.sv */
module cgsb_delay (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  cgsb_pkg::ctx_t in_ctx,
  output logic           out_valid,
  output cgsb_pkg::ctx_t out_ctx
);

  localparam int L = cgsb_pkg::UNIT_LAT;

  cgsb_pkg::ctx_t ctx [0:L-1];
  logic [L-1:0]   vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx[0] <= in_ctx;
      for (int k = 1; k < L; k++) begin
        ctx[k] <= ctx[k-1];
      end
    end
  end

  assign out_valid = vld[L-1];
  assign out_ctx   = ctx[L-1];

endmodule

/* src/cfd_ghost_state_boundary.sv */
// Channel  Role    Handshake      Word
// face     sink    valid/ready    opcode, interior state, face normal
// ghost    source  valid/ready    ghost state and status
// cfg      sink    valid/ready    register index and write data
//
// One word is accepted every cycle while the skid register is empty; face.ready is low while it holds a word.
// The latency is set by three chained divider and square root pipelines.
// Reset is synchronous and restores the register defaults and clears all valid bits.
// A skid register behind the output register keeps the pipeline moving for one more word
// while a result is held; the pipeline then freezes as a whole and nothing is lost.
module cfd_ghost_state_boundary (
  input logic         clk,
  input logic         rst,
  cgsb_face_if.sink   face,
  cgsb_ghost_if.source ghost,
  cgsb_cfg_if.sink    cfg
);

  logic [cgsb_pkg::DIM_W-1:0]   dim;
  logic [cgsb_pkg::GAMMA_W-1:0] gamma;
  logic                         viscous;
  cgsb_pkg::word_t              bc [0:cgsb_pkg::NUM_BC-1];

  logic            dim3;
  cgsb_pkg::word_t gam_w;
  logic            en;

  cgsb_pkg::ctx_t c0, c0_next, c1, c1_next, c2, c2_next, c3, c3_next, c4, c4_next;
  logic           v0, v1, v2, v3, v4;
  cgsb_pkg::ctx_t dc1, dc2, dc3;
  logic           dv1, dv2, dv3;

  cgsb_pkg::word_t q1, r1, d1, area1, c3r, a3;
  logic            q1_dz, r1_dz, d1_dz, area1_neg, c3_neg, a3_dz;
  cgsb_pkg::word_t vq [0:2];
  logic [2:0]      vq_dz;

  cgsb_pkg::out_word_t res, res_next, out_q, skid_q;
  logic                res_v, out_v, skid_v;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim     <= cgsb_pkg::DIM_RST;
      gamma   <= cgsb_pkg::GAMMA_RST;
      viscous <= 1'b0;
      bc[0]   <= cgsb_pkg::ONE_FX;
      bc[1]   <= '0;
      bc[2]   <= '0;
      bc[3]   <= '0;
      bc[4]   <= cgsb_pkg::ONE_FX;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        cgsb_pkg::REG_DIMENSION:   dim     <= cfg.data[cgsb_pkg::DIM_W-1:0];
        cgsb_pkg::REG_GAMMA:       gamma   <= cfg.data[cgsb_pkg::GAMMA_W-1:0];
        cgsb_pkg::REG_VISCOUS:     viscous <= cfg.data[0];
        cgsb_pkg::REG_BC_DENSITY:  bc[0]   <= cgsb_pkg::word_t'(cfg.data);
        cgsb_pkg::REG_BC_VEL_X:    bc[1]   <= cgsb_pkg::word_t'(cfg.data);
        cgsb_pkg::REG_BC_VEL_Y:    bc[2]   <= cgsb_pkg::word_t'(cfg.data);
        cgsb_pkg::REG_BC_VEL_Z:    bc[3]   <= cgsb_pkg::word_t'(cfg.data);
        cgsb_pkg::REG_BC_PRESSURE: bc[4]   <= cgsb_pkg::word_t'(cfg.data);
        default: begin
        end
      endcase
    end
  end

  assign dim3  = (dim == cgsb_pkg::DIM_RST);
  assign gam_w = cgsb_pkg::word_t'({{(cgsb_pkg::WORD_W-cgsb_pkg::GAMMA_W){1'b0}}, gamma});

  assign en         = !skid_v;
  assign face.ready = en;

  always_comb begin
    c0_next      = '0;
    c0_next.op   = cgsb_pkg::op_t'(face.data.opcode);
    c0_next.rho  = face.data.density_in;
    c0_next.p    = face.data.pressure_in;
    c0_next.u[0] = face.data.vel_x_in;
    c0_next.u[1] = face.data.vel_y_in;
    c0_next.u[2] = dim3 ? face.data.vel_z_in : '0;
    c0_next.n[0] = face.data.normal_x;
    c0_next.n[1] = face.data.normal_y;
    c0_next.n[2] = dim3 ? face.data.normal_z : '0;
    for (int i = 0; i < 3; i++) begin
      c0_next.nsq[i] = cgsb_pkg::fmul(c0_next.n[i], c0_next.n[i]);
      c0_next.un[i]  = cgsb_pkg::fmul(c0_next.u[i], c0_next.n[i]);
    end
    c0_next.gp = cgsb_pkg::fmul(gam_w, face.data.pressure_in);
  end

  always_comb begin
    c1_next     = c0;
    c1_next.nn  = cgsb_pkg::sadd(cgsb_pkg::sadd(c0.nsq[0], c0.nsq[1]), c0.nsq[2]);
    c1_next.dot = cgsb_pkg::sadd(cgsb_pkg::sadd(c0.un[0], c0.un[1]), c0.un[2]);
  end

  cgsb_div u_div_q (.clk(clk), .en(en), .num(c1.gp), .den(c1.rho), .quo(q1), .dz(q1_dz));
  cgsb_div u_div_r (.clk(clk), .en(en), .num(bc[4]), .den(c1.p), .quo(r1), .dz(r1_dz));
  cgsb_div u_div_d (.clk(clk), .en(en), .num(c1.dot), .den(c1.nn), .quo(d1), .dz(d1_dz));
  cgsb_sqrt u_sqrt_area (.clk(clk), .en(en), .a(c1.nn), .root(area1), .neg(area1_neg));
  cgsb_delay u_dly1 (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v1), .in_ctx(c1), .out_valid(dv1), .out_ctx(dc1)
  );

  always_comb begin
    c2_next            = dc1;
    c2_next.q          = q1;
    c2_next.d          = d1;
    c2_next.area       = area1;
    c2_next.alpha      = cgsb_pkg::ssub(r1, cgsb_pkg::ONE_FX);
    c2_next.fault_out  = q1_dz | r1_dz | area1_neg;
    c2_next.fault_wall = d1_dz;
    for (int i = 0; i < 3; i++) begin
      c2_next.wall[i] = cgsb_pkg::ssub(dc1.u[i], cgsb_pkg::fmul(d1, dc1.n[i]));
    end
  end

  cgsb_sqrt u_sqrt_c (.clk(clk), .en(en), .a(c2.q), .root(c3r), .neg(c3_neg));
  cgsb_div u_div_a (.clk(clk), .en(en), .num(c2.alpha), .den(gam_w), .quo(a3), .dz(a3_dz));
  cgsb_delay u_dly2 (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v2), .in_ctx(c2), .out_valid(dv2), .out_ctx(dc2)
  );

  always_comb begin
    c3_next           = dc2;
    c3_next.c         = c3r;
    c3_next.a         = a3;
    c3_next.fault_out = dc2.fault_out | c3_neg | a3_dz;
    c3_next.ac        = cgsb_pkg::fmul(a3, c3r);
    c3_next.rho_g     = cgsb_pkg::fmul(cgsb_pkg::sadd(cgsb_pkg::ONE_FX, a3), dc2.rho);
  end

  always_comb begin
    c4_next = c3;
    for (int i = 0; i < 3; i++) begin
      c4_next.acn[i] = cgsb_pkg::fmul(c3.ac, c3.n[i]);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_vdiv
    cgsb_div u_div_v (
      .clk(clk), .en(en), .num(c4.acn[i]), .den(c4.area), .quo(vq[i]), .dz(vq_dz[i])
    );
  end

  cgsb_delay u_dly3 (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v4), .in_ctx(c4), .out_valid(dv3), .out_ctx(dc3)
  );

  always_comb begin
    logic flt;
    res_next = '0;
    flt      = 1'b0;
    unique case (dc3.op)
      cgsb_pkg::OP_DIRICHLET: begin
        res_next.density_out  = bc[0];
        res_next.vel_x_out    = bc[1];
        res_next.vel_y_out    = bc[2];
        res_next.vel_z_out    = dim3 ? bc[3] : '0;
        res_next.pressure_out = bc[4];
      end
      cgsb_pkg::OP_OUTFLOW: begin
        res_next.density_out  = dc3.rho_g;
        res_next.vel_x_out    = cgsb_pkg::ssub(dc3.u[0], vq[0]);
        res_next.vel_y_out    = cgsb_pkg::ssub(dc3.u[1], vq[1]);
        res_next.vel_z_out    = dim3 ? cgsb_pkg::ssub(dc3.u[2], vq[2]) : '0;
        res_next.pressure_out = bc[4];
        flt                   = dc3.fault_out | (|vq_dz);
      end
      cgsb_pkg::OP_WALL: begin
        res_next.density_out  = dc3.rho;
        res_next.pressure_out = dc3.p;
        if (!viscous) begin
          res_next.vel_x_out = dc3.wall[0];
          res_next.vel_y_out = dc3.wall[1];
          res_next.vel_z_out = dc3.wall[2];
          flt                = dc3.fault_wall;
        end
      end
      cgsb_pkg::OP_COPY: begin
        res_next.density_out  = dc3.rho;
        res_next.vel_x_out    = dc3.u[0];
        res_next.vel_y_out    = dc3.u[1];
        res_next.vel_z_out    = dc3.u[2];
        res_next.pressure_out = dc3.p;
      end
    endcase
    if (flt) begin
      res_next.density_out  = cgsb_pkg::MAXW;
      res_next.vel_x_out    = cgsb_pkg::MAXW;
      res_next.vel_y_out    = cgsb_pkg::MAXW;
      res_next.vel_z_out    = dim3 ? cgsb_pkg::MAXW : '0;
      res_next.pressure_out = cgsb_pkg::MAXW;
    end
    res_next.status = flt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      res_v <= 1'b0;
    end else if (en) begin
      v0    <= face.valid;
      v1    <= v0;
      v2    <= dv1;
      v3    <= dv2;
      v4    <= v3;
      res_v <= dv3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0  <= c0_next;
      c1  <= c1_next;
      c2  <= c2_next;
      c3  <= c3_next;
      c4  <= c4_next;
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (out_v && !ghost.ready) begin
      if (en && res_v) begin
        skid_q <= res;
        skid_v <= 1'b1;
      end
    end else if (skid_v) begin
      out_q  <= skid_q;
      out_v  <= 1'b1;
      skid_v <= 1'b0;
    end else begin
      out_q <= res;
      out_v <= res_v;
    end
  end

  assign ghost.valid = out_v;
  assign ghost.data  = out_q;

`ifndef NO_ASSERTIONS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid register holds a word while the output register is empty");
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_v && ghost.ready) |=> !skid_v)
    else $error("skid register did not drain after the output was taken");
  a_fault_saturates: assert property (@(posedge clk) disable iff (rst)
    (out_v && out_q.status) |->
      (out_q.density_out == cgsb_pkg::MAXW && out_q.pressure_out == cgsb_pkg::MAXW))
    else $error("faulted result is not saturated");
`endif

endmodule
